// File: design/led_mux_with_button_scan_top_defines.svh
// ----------------------------------------------------------------------------
// led_mux_with_button_scan_top_defines.svh
// Assertion macros used by the display and key scan top level.
// ----------------------------------------------------------------------------
`ifndef LED_MUX_WITH_BUTTON_SCAN_TOP_DEFINES_SVH
`define LED_MUX_WITH_BUTTON_SCAN_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LMBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmbs assertion failed");
// next-cycle implication
`define LMBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmbs assertion failed");
`else
`define LMBS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LMBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/lmbs_pkg.sv
// ----------------------------------------------------------------------------
// lmbs_pkg
// Types, codes and the segment table of the display and key scan block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmbs_pkg;

    localparam int NUM_DIGITS = 4;

    // request kinds
    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_SCAN   = 2'd1,
        REQ_SAMPLE = 2'd2
    } t_req;

    // configuration register indexes
    localparam logic [1:0] CFG_PRESS   = 2'd0;
    localparam logic [1:0] CFG_LONG    = 2'd1;
    localparam logic [1:0] CFG_FLOOR   = 2'd2;

    localparam logic [7:0] PRESS_RST = 8'd5;
    localparam logic [7:0] LONG_RST  = 8'd100;
    localparam logic [7:0] FLOOR_RST = 8'd1;

    localparam logic [7:0] SEG_BLANK = 8'h00;

    // debounce step result for one button
    typedef struct packed {
        logic [7:0] counter;
        logic       set_short;
        logic       set_long;
        logic       clear;
    } t_dbn_res;

    function automatic logic [7:0] seg_lookup(input logic [3:0] code);
        logic [7:0] seg;
        case (code)
            4'd0:    seg = 8'h6f;
            4'd1:    seg = 8'h60;
            4'd2:    seg = 8'ha7;
            4'd3:    seg = 8'he6;
            4'd4:    seg = 8'he8;
            4'd5:    seg = 8'hce;
            4'd6:    seg = 8'hcf;
            4'd7:    seg = 8'h62;
            4'd8:    seg = 8'hef;
            4'd9:    seg = 8'hee;
            4'd10:   seg = 8'h80;
            4'd12:   seg = 8'haa;
            default: seg = SEG_BLANK; // blank and codes above twelve
        endcase
        return seg;
    endfunction

endpackage

// File: design/lmbs_if.sv
// ----------------------------------------------------------------------------
// lmbs_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lmbs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [1:0] digit_position;
    logic [3:0] digit_code;
    logic       button_level;

    modport source (output valid, req_type, digit_position, digit_code, button_level,
                    input ready);
    modport sink   (input valid, req_type, digit_position, digit_code, button_level,
                    output ready);
endinterface

interface lmbs_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] segments;
    logic [3:0] digit_enable;
    logic [7:0] button_flags;

    modport source (output valid, segments, digit_enable, button_flags, input ready);
    modport sink   (input valid, segments, digit_enable, button_flags, output ready);
endinterface

// File: design/lmbs_debounce.sv
// ----------------------------------------------------------------------------
// lmbs_debounce
// One debounce step of the selected button's press counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmbs_debounce import lmbs_pkg::*; (
    input  logic [7:0] i_counter,
    input  logic       i_level,
    input  logic [7:0] i_press,
    input  logic [7:0] i_long,
    input  logic [7:0] i_floor,
    output t_dbn_res   o_res
);

    logic [7:0] c_inc;
    logic [7:0] c_cap;
    logic [7:0] c_dec;

    always_comb begin
        c_inc = (i_counter != 8'hff) ? i_counter + 8'd1 : i_counter;
        c_cap = (i_counter > i_press) ? i_press : i_counter;
        c_dec = c_cap - 8'd1;
        o_res = '0;
        if (i_level) begin
            o_res.counter = c_inc;
            if (c_inc == i_press) begin
                o_res.set_short = 1'b1;
            end else if (c_inc == i_long) begin
                o_res.set_long = 1'b1;
            end else if (c_inc > i_long) begin
                o_res.counter = i_long;
            end
        end else begin
            // falling under the floor (or zero) releases the button
            if (c_cap == 8'd0 || c_dec < i_floor) begin
                o_res.counter = i_floor;
                o_res.clear   = 1'b1;
            end else begin
                o_res.counter = c_dec;
            end
        end
    end

endmodule

// File: design/led_mux_with_button_scan_top.sv
// ----------------------------------------------------------------------------
// led_mux_with_button_scan_top
// Four-digit multiplexed seven-segment driver with per-digit key debounce.
// ----------------------------------------------------------------------------
//  channel     | dir | handshake   | payload
//  i_req_ch    | in  | valid/ready | req_type, digit_position, digit_code, button_level
//  o_res_ch    | out | valid/ready | segments, digit_enable, button_flags
//  i_cfg_*     | in  | write only  | i_cfg_idx, i_cfg_wdata
//
//  One transaction per cycle unless the result is stalled; input register, then result register.
//  Each transaction gives exactly one result showing the state after it.
//  Ready drops only while both the input and result registers are full and
//  the result is not taken. Synchronous active-low reset clears all but payload registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "led_mux_with_button_scan_top_defines.svh"

module led_mux_with_button_scan_top import lmbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    lmbs_req_if.sink   i_req_ch,
    lmbs_res_if.source o_res_ch
);

    // configuration
    logic [7:0] r_press, r_long, r_floor;

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_req;
    logic [1:0] r_in_pos;
    logic [3:0] r_in_code;
    logic       r_in_level;

    // block state
    logic [1:0] r_scan,   n_scan;
    logic [7:0] r_patterns [NUM_DIGITS];
    logic [7:0] n_patterns [NUM_DIGITS];
    logic [7:0] r_counters [NUM_DIGITS];
    logic [7:0] n_counters [NUM_DIGITS];
    logic [7:0] r_flags,  n_flags;
    logic       r_on,     n_on;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_seg;
    logic [3:0] r_out_en;
    logic [7:0] r_out_flags;

    logic       w_out_free;
    logic       w_proc;
    logic       w_in_acc;
    logic [3:0] w_bit;
    t_dbn_res   w_dbn;

    assign w_out_free = !r_out_valid || o_res_ch.ready;
    assign w_proc     = r_in_valid && w_out_free;
    assign i_req_ch.ready = !r_in_valid || w_out_free;
    assign w_in_acc   = i_req_ch.valid && i_req_ch.ready;

    assign o_res_ch.valid        = r_out_valid;
    assign o_res_ch.segments     = r_out_seg;
    assign o_res_ch.digit_enable = r_out_en;
    assign o_res_ch.button_flags = r_out_flags;

    lmbs_debounce u_debounce (
        .i_counter (r_counters[r_scan]),
        .i_level   (r_in_level),
        .i_press   (r_press),
        .i_long    (r_long),
        .i_floor   (r_floor),
        .o_res     (w_dbn)
    );

    assign w_bit = 4'(4'b0001 << r_scan);

    always_comb begin
        n_scan     = r_scan;
        n_patterns = r_patterns;
        n_counters = r_counters;
        n_flags    = r_flags;
        n_on       = r_on;
        if (w_proc) begin
            case (r_in_req)
                REQ_WRITE: begin
                    n_patterns[r_in_pos] = seg_lookup(r_in_code);
                end
                REQ_SCAN: begin
                    n_scan = r_scan + 2'd1;
                    n_on   = 1'b1;
                end
                REQ_SAMPLE: begin
                    n_counters[r_scan] = w_dbn.counter;
                    n_flags = r_flags
                            | ({4'b0000, w_bit} & {8{w_dbn.set_short}})
                            | ({w_bit, 4'b0000} & {8{w_dbn.set_long}});
                    if (w_dbn.clear) begin
                        n_flags = n_flags & ~{w_bit, w_bit};
                    end
                    n_on = 1'b0;
                end
                default: ; // unused kind leaves the state alone
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press     <= PRESS_RST;
            r_long      <= LONG_RST;
            r_floor     <= FLOOR_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
            r_flags     <= '0;
            r_on        <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_patterns[i] <= SEG_BLANK;
                r_counters[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PRESS: r_press <= i_cfg_wdata;
                    CFG_LONG:  r_long  <= i_cfg_wdata;
                    CFG_FLOOR: r_floor <= i_cfg_wdata;
                    default:   ;
                endcase
            end
            if (i_req_ch.ready) begin
                r_in_valid <= i_req_ch.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            r_scan     <= n_scan;
            r_patterns <= n_patterns;
            r_counters <= n_counters;
            r_flags    <= n_flags;
            r_on       <= n_on;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_req   <= i_req_ch.req_type;
            r_in_pos   <= i_req_ch.digit_position;
            r_in_code  <= i_req_ch.digit_code;
            r_in_level <= i_req_ch.button_level;
        end
        if (w_proc) begin
            r_out_seg   <= n_patterns[n_scan];
            r_out_en    <= n_on ? 4'(4'b0001 << n_scan) : 4'b0000;
            r_out_flags <= n_flags;
        end
    end

    `LMBS_ASSERT_NEXT(a_scan_lights, i_clk, i_rst_n,
        w_proc && r_in_req == REQ_SCAN, $onehot(r_out_en) && r_out_valid)
    `LMBS_ASSERT_NEXT(a_sample_blanks, i_clk, i_rst_n,
        w_proc && r_in_req == REQ_SAMPLE, r_out_en == 4'b0000)
    `LMBS_ASSERT_NEXT(a_no_drop, i_clk, i_rst_n,
        r_in_valid && !w_out_free, r_in_valid && r_out_valid)
    `LMBS_ASSERT_NEXT(a_write_shows, i_clk, i_rst_n,
        w_proc && r_in_req == REQ_WRITE && r_in_pos == r_scan,
        r_out_seg == seg_lookup($past(r_in_code)))

endmodule

// File: dv/led_mux_with_button_scan_top_tb.sv
// ----------------------------------------------------------------------------
// led_mux_with_button_scan_top_tb
// Self-checking bench for the display mux and key debounce block. Requests
// come from a queue in random bursts, and results are drained under changing
// stall patterns and two long hold-offs. Each result is compared against a
// local model of the digit store, scan position and debounce counters.
// Thresholds are reloaded between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_mux_with_button_scan_top_tb;
    import lmbs_pkg::*;

    localparam int         CLK_HALF    = 4;
    localparam int         RST_CYCLES  = 10;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         LONG_HOLD   = 300;
    localparam int         END_DRAIN   = 10;
    localparam int         NUM_PHASES  = 8;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam logic [3:0] CODE_MINUS  = 4'd10;
    localparam logic [3:0] CODE_BLANK  = 4'd11;
    localparam logic [3:0] CODE_AA     = 4'd12;

    localparam logic [7:0] SEG_CODES [0:12] = '{
        8'h6f, 8'h60, 8'ha7, 8'he6, 8'he8, 8'hce, 8'hcf, 8'h62, 8'hef, 8'hee,
        8'h80, SEG_BLANK, 8'haa
    };

    // press, long, floor; one set has the thresholds out of order on purpose
    localparam logic [7:0] THR_SETS [0:4][0:2] = '{
        '{8'd1,   8'd2,   8'd0},
        '{8'd254, 8'd255, 8'd253},
        '{8'd3,   8'd12,  8'd1},
        '{8'd200, 8'd10,  8'd50},
        '{8'd2,   8'd6,   8'd0}
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] slot;
        logic [3:0] code;
        logic       level;
    } t_key_req;

    typedef struct packed {
        logic [7:0] seg;
        logic [3:0] dig_en;
        logic [7:0] flags;
    } t_disp_out;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_wdata;

    lmbs_req_if req_ch ();
    lmbs_res_if res_ch ();

    led_mux_with_button_scan_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_ch    (req_ch),
        .o_res_ch    (res_ch)
    );

    // display and debounce model state
    logic [7:0] thr_press, thr_long, thr_floor;
    logic [1:0] scan_pos;
    logic [7:0] digit_pat [0:3];
    logic [7:0] press_cnt [0:3];
    logic [7:0] btn_flags;
    logic       digits_lit;

    t_key_req    key_req_q [$];
    t_disp_out   disp_expect_q [$];
    int unsigned items_queued;
    int unsigned err_cnt;
    int unsigned cycle_cnt;

    // sender side
    logic        req_fire;
    int unsigned burst_left, gap_left, tx_gap_max;

    // receiver side
    int unsigned hold_reqs, holds_done, hold_left, pat_left;
    logic [7:0]  stall_pat;
    logic [2:0]  pat_idx;

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic log_error(string msg);
        err_cnt++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // applies one request to the model and returns the display state after it
    function automatic t_disp_out predict_display(t_key_req rq);
        t_disp_out r;
        int        p;
        int        c;
        case (rq.kind)
            REQ_WRITE: begin
                digit_pat[rq.slot] = (rq.code <= CODE_AA) ? SEG_CODES[rq.code] : SEG_BLANK;
            end
            REQ_SCAN: begin
                scan_pos   = scan_pos + 2'd1;
                digits_lit = 1'b1;
            end
            REQ_SAMPLE: begin
                p = scan_pos;
                c = press_cnt[p];
                if (rq.level) begin
                    if (c < 255)
                        c++;
                    if (c == thr_press) begin
                        btn_flags[p] = 1'b1;
                    end else if (c == thr_long) begin
                        btn_flags[p + 4] = 1'b1;
                    end else if (c > thr_long) begin
                        c = thr_long;
                    end
                end else begin
                    if (c > thr_press)
                        c = thr_press;
                    if (c == 0 || c - 1 < thr_floor) begin
                        c                = thr_floor;
                        btn_flags[p]     = 1'b0;
                        btn_flags[p + 4] = 1'b0;
                    end else begin
                        c--;
                    end
                end
                press_cnt[p] = c[7:0];
                digits_lit   = 1'b0;
            end
            default: ;
        endcase
        r.seg    = digit_pat[scan_pos];
        r.dig_en = digits_lit ? (4'b0001 << scan_pos) : 4'b0000;
        r.flags  = btn_flags;
        return r;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        t_key_req nxt;
        if (i_rst_n && (!req_ch.valid || req_fire)) begin
            if (burst_left == 0 && gap_left == 0)
                burst_left = $urandom_range(1, 24);
            if (gap_left != 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else if (key_req_q.size() != 0) begin
                nxt = key_req_q.pop_front();
                req_ch.valid          <= 1'b1;
                req_ch.req_type       <= nxt.kind;
                req_ch.digit_position <= nxt.slot;
                req_ch.digit_code     <= nxt.code;
                req_ch.button_level   <= nxt.level;
                burst_left--;
                if (burst_left == 0)
                    gap_left = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result ready: stall pattern reloaded when its random run count expires, plus long holds
    always @(negedge i_clk) begin
        if (hold_reqs != holds_done) begin
            holds_done++;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            if (pat_left == 0) begin
                pat_left = $urandom_range(16, 64);
                case ($urandom_range(0, 3))
                    0, 1:    stall_pat = 8'hff;
                    2:       stall_pat = 8'($urandom) | 8'h01;
                    default: stall_pat = (8'($urandom) & 8'($urandom)) | 8'h01;
                endcase
            end
            pat_left--;
            res_ch.ready <= stall_pat[pat_idx];
            pat_idx = pat_idx + 3'd1;
        end
    end

    // monitor: predict on request transaction, check on result transaction
    always @(posedge i_clk) begin
        t_disp_out want;
        if (!i_rst_n) begin
            req_fire <= 1'b0;
        end else begin
            req_fire <= req_ch.valid && req_ch.ready;
            if (res_ch.valid && res_ch.ready) begin
                if (disp_expect_q.size() == 0) begin
                    log_error($sformatf("result with nothing pending seg %02h en %01h flags %02h",
                                        res_ch.segments, res_ch.digit_enable,
                                        res_ch.button_flags));
                end else begin
                    want = disp_expect_q.pop_front();
                    if (res_ch.segments !== want.seg)
                        log_error($sformatf("segments got %02h want %02h",
                                            res_ch.segments, want.seg));
                    if (res_ch.digit_enable !== want.dig_en)
                        log_error($sformatf("digit_enable got %01h want %01h",
                                            res_ch.digit_enable, want.dig_en));
                    if (res_ch.button_flags !== want.flags)
                        log_error($sformatf("button_flags got %02h want %02h",
                                            res_ch.button_flags, want.flags));
                end
            end
            if (req_ch.valid && req_ch.ready)
                disp_expect_q.push_back(predict_display('{req_ch.req_type, req_ch.digit_position,
                                                          req_ch.digit_code,
                                                          req_ch.button_level}));
        end
    end

    task automatic push_req(logic [1:0] kind, logic [1:0] slot, logic [3:0] code, logic level);
        key_req_q.push_back('{kind, slot, code, level});
        if (kind != REQ_UNUSED)
            items_queued++;
    endtask

    // mostly press/release sequences on the scanned digit, some noise
    task automatic gen_phase(int unsigned n_items);
        int unsigned start, n_press, n_rel, lo, hi, lim;
        start = items_queued;
        while (items_queued - start < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(0, 2))
                    push_req(REQ_WRITE, 2'($urandom), 4'($urandom), 1'($urandom));
                repeat ($urandom_range(0, 2))
                    push_req(REQ_SCAN, 2'($urandom), 4'($urandom), 1'($urandom));
                lim = (thr_press > 12) ? 12 : thr_press;
                if ($urandom_range(0, 3) == 0) begin
                    lo = (thr_long > 3) ? thr_long - 3 : 1;
                    hi = thr_long + 4;
                    n_press = $urandom_range(lo, hi);
                end else begin
                    n_press = $urandom_range(1, lim + 3);
                end
                repeat (n_press) push_req(REQ_SAMPLE, 2'($urandom), 4'($urandom), 1'b1);
                n_rel = $urandom_range(1, lim + 3);
                repeat (n_rel) push_req(REQ_SAMPLE, 2'($urandom), 4'($urandom), 1'b0);
            end else begin
                repeat ($urandom_range(1, 4))
                    push_req(2'($urandom), 2'($urandom), 4'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic wait_idle();
        while (key_req_q.size() != 0 || req_ch.valid || disp_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_PRESS: thr_press = val;
            CFG_LONG:  thr_long  = val;
            default:   thr_floor = val;
        endcase
    endtask

    initial begin
        logic [7:0] set_press, set_long, set_floor;
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_PRESS;
        i_cfg_wdata           = 8'd0;
        req_ch.valid          = 1'b0;
        req_ch.req_type       = REQ_WRITE;
        req_ch.digit_position = 2'd0;
        req_ch.digit_code     = 4'd0;
        req_ch.button_level   = 1'b0;
        res_ch.ready          = 1'b0;
        thr_press  = PRESS_RST;
        thr_long   = LONG_RST;
        thr_floor  = FLOOR_RST;
        scan_pos   = 2'd0;
        btn_flags  = 8'd0;
        digits_lit = 1'b0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_pat[i] = SEG_BLANK;
            press_cnt[i] = 8'd0;
        end
        items_queued = 0;
        err_cnt      = 0;
        cycle_cnt    = 0;
        burst_left   = 0;
        gap_left     = 0;
        tx_gap_max   = 4;
        hold_reqs    = 0;
        holds_done   = 0;
        hold_left    = 0;
        pat_left     = 0;
        stall_pat    = 8'hff;
        pat_idx      = 3'd0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // release with an empty counter goes straight to the floor
        push_req(REQ_SAMPLE, 2'd0, 4'd0, 1'b0);
        // write to the displayed slot shows at once
        push_req(REQ_WRITE, 2'd0, 4'd8, 1'b0);
        push_req(REQ_WRITE, 2'd1, 4'd15, 1'b1);
        push_req(REQ_WRITE, 2'd2, CODE_AA, 1'b0);
        push_req(REQ_WRITE, 2'd3, CODE_MINUS, 1'b1);
        push_req(REQ_WRITE, 2'd1, CODE_BLANK, 1'b0);
        push_req(REQ_UNUSED, 2'd3, 4'd15, 1'b1);
        push_req(REQ_SCAN, 2'd2, 4'd5, 1'b0);
        repeat (6) push_req(REQ_SAMPLE, 2'd0, 4'd0, 1'b1);
        push_req(REQ_SAMPLE, 2'd3, 4'd15, 1'b0);
        // three more scans wrap the position back to slot 0
        repeat (3) push_req(REQ_SCAN, 2'd1, 4'd3, 1'b1);
        push_req(REQ_WRITE, 2'd0, 4'd13, 1'b0);
        push_req(REQ_WRITE, 2'd0, 4'd14, 1'b1);
        push_req(REQ_WRITE, 2'd0, 4'd9, 1'b0);
        push_req(REQ_WRITE, 2'd2, 4'd0, 1'b1);
        gen_phase(150);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 5) begin
                set_press = THR_SETS[ph][0];
                set_long  = THR_SETS[ph][1];
                set_floor = THR_SETS[ph][2];
            end else if (ph < NUM_PHASES - 1) begin
                set_press = 8'($urandom_range(1, 254));
                set_long  = 8'($urandom_range(2, 255));
                set_floor = 8'($urandom_range(0, 253));
            end else begin
                set_press = PRESS_RST;
                set_long  = LONG_RST;
                set_floor = FLOOR_RST;
            end
            write_cfg(CFG_PRESS, set_press);
            write_cfg(CFG_LONG, set_long);
            write_cfg(CFG_FLOOR, set_floor);
            @(negedge i_clk);
            i_cfg_we <= 1'b0;

            tx_gap_max = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 3 : 8);
            // receiver holds off while requests keep coming, so input backs up
            if (ph == 1 || ph == 5)
                hold_reqs++;
            gen_phase(175);
            wait_idle();
        end

        repeat (END_DRAIN) @(posedge i_clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
